@@ rtl/core/gnw_pkg.sv @@
// ----------------------------------------------------------------------------
// GPS navigation word package
// Shared types, constants and parity helpers for the word parity and
// frame sync block.
// ----------------------------------------------------------------------------
`default_nettype none

package gnw_pkg;

  localparam int unsigned RawWidth   = 30;
  localparam int unsigned DataWidth  = 24;
  localparam int unsigned SlotWidth  = 6;
  localparam int unsigned ParWidth   = 6;
  localparam int unsigned SubWidth   = 3;
  localparam int unsigned PosWidth   = 4;

  localparam logic [SubWidth-1:0] LastSub = 3'd4;
  localparam logic [PosWidth-1:0] LastPos = 4'd9;
  localparam logic [PosWidth-1:0] PosTlm  = 4'd0;
  localparam logic [PosWidth-1:0] PosHow  = 4'd1;
  localparam logic [SlotWidth-1:0] LastSlot = 6'd49;
  localparam logic [SlotWidth-1:0] FrameWords = 6'd50;

  localparam logic [7:0] Preamble = 8'h8b;

  localparam logic [DataWidth-1:0] ParMask [ParWidth] = '{
    24'h2dea27, 24'haec7cd, 24'h5d8f9a, 24'hbb1f34, 24'h763e69, 24'hec7cd2
  };

  // Set where the parity bit is seeded from the previous D30, else from D29.
  localparam logic [ParWidth-1:0] ParUsesD30 = 6'b010110;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_PARITY_ERR  = 2'd1,
    ST_OUT_OF_SYNC = 2'd2
  } gnw_status_e;

  typedef struct packed {
    logic                 par_ok;
    logic                 d29;
    logic                 d30;
    logic                 preamble_ok;
    logic [SubWidth-1:0]  sub_id;
    logic [DataWidth-1:0] data;
  } gnw_check_t;

  typedef struct packed {
    gnw_status_e          status;
    logic [SlotWidth-1:0] slot;
    logic [DataWidth-1:0] data_bits;
    logic                 frame_done;
  } gnw_result_t;

  function automatic logic [ParWidth-1:0] calc_parity(
    input logic [DataWidth-1:0] data,
    input logic                 prev_d29,
    input logic                 prev_d30
  );
    logic [ParWidth-1:0] par;
    par = '0;
    for (int i = 0; i < ParWidth; i++) begin
      par[i] = (ParUsesD30[i] ? prev_d30 : prev_d29) ^ (^(data & ParMask[i]));
    end
    return par;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/gnw_in_if.sv @@
// ----------------------------------------------------------------------------
// Raw word channel
// Valid/ready channel that carries one raw 30-bit navigation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnw_in_if
  import gnw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RawWidth-1:0] raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink (input valid, input raw_word, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gnw_out_if.sv @@
// ----------------------------------------------------------------------------
// Word result channel
// Valid/ready channel that carries the status, slot and corrected data of
// one checked word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnw_out_if
  import gnw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [SlotWidth-1:0] slot;
  logic [DataWidth-1:0] data_bits;
  logic                 frame_done;

  modport source (output valid, output status, output slot, output data_bits,
                  output frame_done, input ready);
  modport sink (input valid, input status, input slot, input data_bits,
                input frame_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gps_nav_word_parity_frame_sync.sv @@
// ----------------------------------------------------------------------------
// GPS navigation word parity and frame sync
// Checks the parity of each navigation word and tracks subframe sync over
// the 50-word frame.
// ----------------------------------------------------------------------------
// Each accepted word produces exactly one result transaction. A word is
// captured in an input register, checked and sync-tested from that
// register, and its result is held in an output register until taken;
// one word per cycle is sustained while the output is ready, and a held
// result keeps the next word in the input register. The only loop is the
// frame position and parity history, which updates in the same cycle as the result register loads.
`default_nettype none

module gps_nav_word_parity_frame_sync
  import gnw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  gnw_in_if.sink     in_i,
  gnw_out_if.source  out_o
);

  logic                s1_valid_q;
  logic [RawWidth-1:0] raw_q;
  logic                out_valid_q;
  gnw_result_t         res_q;

  logic        s1_fire;
  logic        prev_d29;
  logic        prev_d30;
  gnw_check_t  check;
  gnw_result_t res_c;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;

  gnw_word_check u_check (
    .raw_word_i (raw_q),
    .prev_d29_i (prev_d29),
    .prev_d30_i (prev_d30),
    .check_o    (check)
  );

  gnw_frame_sync u_sync (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .check_i    (check),
    .prev_d29_o (prev_d29),
    .prev_d30_o (prev_d30),
    .result_o   (res_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      raw_q <= in_i.raw_word;
    end
    if (s1_fire) begin
      res_q <= res_c;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = res_q.status;
  assign out_o.slot       = res_q.slot;
  assign out_o.data_bits  = res_q.data_bits;
  assign out_o.frame_done = res_q.frame_done;

  a_done_is_last_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_done |->
      (out_o.status == ST_ACCEPTED) && (out_o.slot == LastSlot))
    else $error("frame_done on a word that is not an accepted last slot");

  a_slot_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.slot < FrameWords))
    else $error("result slot beyond the frame");

  a_restart_on_fail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (res_c.status != ST_ACCEPTED) |=> (res_c.slot == '0))
    else $error("frame position did not restart after a failed word");

endmodule

`default_nettype wire

@@ rtl/core/gnw_word_check.sv @@
// ----------------------------------------------------------------------------
// Word check
// Complements the data bits by the previous D30 and checks the six
// Hamming parity bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gnw_word_check
  import gnw_pkg::*;
(
  input  logic [RawWidth-1:0] raw_word_i,
  input  logic                prev_d29_i,
  input  logic                prev_d30_i,
  output gnw_check_t          check_o
);

  logic [DataWidth-1:0] data;
  logic [ParWidth-1:0]  par;

  assign data = raw_word_i[RawWidth-1:ParWidth] ^ {DataWidth{prev_d30_i}};
  assign par  = calc_parity(data, prev_d29_i, prev_d30_i);

  always_comb begin
    check_o.par_ok      = (par == raw_word_i[ParWidth-1:0]);
    check_o.d29         = raw_word_i[1];
    check_o.d30         = raw_word_i[0];
    check_o.preamble_ok = (data[DataWidth-1:DataWidth-8] == Preamble);
    check_o.sub_id      = data[4:2];
    check_o.data        = data;
  end

endmodule

`default_nettype wire

@@ rtl/core/gnw_frame_sync.sv @@
// ----------------------------------------------------------------------------
// Frame sync
// Holds the frame position and parity history and applies the subframe
// sync rules to each checked word.
// ----------------------------------------------------------------------------
`default_nettype none

module gnw_frame_sync
  import gnw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  gnw_check_t  check_i,
  output logic        prev_d29_o,
  output logic        prev_d30_o,
  output gnw_result_t result_o
);

  logic                 prev_d29_q, prev_d29_d;
  logic                 prev_d30_q, prev_d30_d;
  logic [SubWidth-1:0]  sub_q, sub_d;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [DataWidth-1:0] first_tlm_q;

  logic slot_zero;
  logic tlm_match;
  logic advance;
  logic [SubWidth-1:0] sub_next;

  assign slot_zero = (sub_q == '0) && (pos_q == PosTlm);
  assign tlm_match = slot_zero || (check_i.data == first_tlm_q);
  assign sub_next  = sub_q + SubWidth'(1);

  always_comb begin
    advance = 1'b0;
    if (pos_q == PosTlm) begin
      advance = check_i.preamble_ok && tlm_match;
    end else if (pos_q == PosHow) begin
      advance = (check_i.sub_id == sub_next) && !check_i.d29 && !check_i.d30;
    end else begin
      advance = 1'b1;
    end
  end

  always_comb begin
    prev_d29_d = prev_d29_q;
    prev_d30_d = prev_d30_q;
    sub_d      = sub_q;
    pos_d      = pos_q;
    result_o.status     = ST_ACCEPTED;
    result_o.frame_done = 1'b0;
    if (!check_i.par_ok) begin
      result_o.status = ST_PARITY_ERR;
      prev_d29_d = 1'b0;
      prev_d30_d = 1'b0;
      sub_d      = '0;
      pos_d      = PosTlm;
    end else begin
      prev_d29_d = check_i.d29;
      prev_d30_d = check_i.d30;
      if (!advance) begin
        result_o.status = ST_OUT_OF_SYNC;
        sub_d = '0;
        pos_d = PosTlm;
      end else if (pos_q == LastPos) begin
        pos_d = PosTlm;
        if (sub_q == LastSub) begin
          sub_d = '0;
          result_o.frame_done = 1'b1;
        end else begin
          sub_d = sub_next;
        end
      end else begin
        pos_d = pos_q + PosWidth'(1);
      end
    end
    result_o.slot = {sub_q, 3'b000} + {2'b00, sub_q, 1'b0} + {2'b00, pos_q};
    result_o.data_bits = check_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_d29_q <= 1'b0;
      prev_d30_q <= 1'b0;
      sub_q      <= '0;
      pos_q      <= PosTlm;
    end else if (fire_i) begin
      prev_d29_q <= prev_d29_d;
      prev_d30_q <= prev_d30_d;
      sub_q      <= sub_d;
      pos_q      <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && slot_zero) begin
      first_tlm_q <= check_i.data;
    end
  end

  assign prev_d29_o = prev_d29_q;
  assign prev_d30_o = prev_d30_q;

endmodule

`default_nettype wire
